### src/lpmd_pkg.sv
package lpmd_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W  = 104;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RECORDS       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RECORD_LENGTH = 2'd1;

	localparam logic [15:0] MAX_RECORDS_RST       = 16'd64;
	localparam logic [23:0] MAX_RECORD_LENGTH_RST = 24'd65535;

	typedef enum logic [1:0] {
		KIND_TITLE   = 2'd0,
		KIND_COUNT   = 2'd1,
		KIND_LENGTH  = 2'd2,
		KIND_PAYLOAD = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_COUNT  = 2'd1,
		ERR_LENGTH = 2'd2
	} err_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		kind_t       byte_kind;
		logic [31:0] title_value;
		logic [15:0] record_total;
		logic [15:0] record_index;
		logic [23:0] record_length;
		logic        payload_last;
		logic        frame_last;
		err_t        error_code;
	} result_t;

endpackage

### src/lpmd_core.sv
module lpmd_core import lpmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  data_byte,
	input  logic [15:0] max_records,
	input  logic [23:0] max_record_length,
	output result_t     result
);

	kind_t       phase_q, phase_d;
	logic [1:0]  pos_q, pos_d;
	logic [31:0] word_q, word_d;
	logic [31:0] title_q, title_d;
	logic [15:0] count_q, count_d;
	logic [15:0] rec_q, rec_d;
	logic [23:0] len_q, len_d;
	logic [23:0] rem_q, rem_d;

	logic [31:0] word_new;
	logic        complete;
	logic        count_bad;
	logic        len_bad;
	logic [15:0] rec_inc;
	logic        last_record;
	logic [23:0] rem_dec;

	assign word_new    = {data_byte, word_q[31:8]};
	assign complete    = (pos_q == 2'd3);
	assign count_bad   = word_new[31] || (word_new[30:16] != 15'd0) ||
		(word_new[15:0] > max_records);
	assign len_bad     = (word_new[31:24] != 8'd0) || (word_new[23:0] > max_record_length);
	assign rec_inc     = rec_q + 16'd1;
	assign last_record = (rec_inc >= count_q);
	assign rem_dec     = rem_q - 24'd1;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		word_d  = word_q;
		title_d = title_q;
		count_d = count_q;
		rec_d   = rec_q;
		len_d   = len_q;
		rem_d   = rem_q;
		if (phase_q != KIND_PAYLOAD) begin
			word_d = word_new;
			pos_d  = pos_q + 2'd1;
		end
		case (phase_q)
			KIND_TITLE: begin
				if (complete) begin
					title_d = word_new;
					phase_d = KIND_COUNT;
				end
			end
			KIND_COUNT: begin
				if (complete) begin
					if (count_bad || (word_new == 32'd0)) begin
						phase_d = KIND_TITLE;
						pos_d   = 2'd0;
						count_d = 16'd0;
						rec_d   = 16'd0;
						len_d   = 24'd0;
						rem_d   = 24'd0;
					end else begin
						count_d = word_new[15:0];
						rec_d   = 16'd0;
						phase_d = KIND_LENGTH;
					end
				end
			end
			KIND_LENGTH: begin
				if (complete) begin
					if (len_bad || ((word_new[23:0] == 24'd0) && last_record)) begin
						phase_d = KIND_TITLE;
						pos_d   = 2'd0;
						count_d = 16'd0;
						rec_d   = 16'd0;
						len_d   = 24'd0;
						rem_d   = 24'd0;
					end else if (word_new[23:0] == 24'd0) begin
						rec_d   = rec_inc;
						phase_d = KIND_LENGTH;
						pos_d   = 2'd0;
						len_d   = 24'd0;
						rem_d   = 24'd0;
					end else begin
						len_d   = word_new[23:0];
						rem_d   = word_new[23:0];
						phase_d = KIND_PAYLOAD;
					end
				end
			end
			KIND_PAYLOAD: begin
				rem_d = rem_dec;
				if (rem_dec == 24'd0) begin
					pos_d = 2'd0;
					len_d = 24'd0;
					if (last_record) begin
						phase_d = KIND_TITLE;
						count_d = 16'd0;
						rec_d   = 16'd0;
					end else begin
						phase_d = KIND_LENGTH;
						rec_d   = rec_inc;
					end
				end
			end
			default: begin
				phase_d = KIND_TITLE;
			end
		endcase
	end

	always_comb begin
		result               = '0;
		result.byte_value    = data_byte;
		result.byte_kind     = phase_q;
		result.error_code    = ERR_NONE;
		case (phase_q)
			KIND_TITLE: begin
				if (complete) begin
					result.title_value = word_new;
				end
			end
			KIND_COUNT: begin
				result.title_value = title_q;
				if (complete) begin
					if (count_bad) begin
						result.error_code = ERR_COUNT;
						result.frame_last = 1'b1;
					end else if (word_new == 32'd0) begin
						result.frame_last = 1'b1;
					end else begin
						result.record_total = word_new[15:0];
					end
				end
			end
			KIND_LENGTH: begin
				result.title_value  = title_q;
				result.record_total = count_q;
				result.record_index = rec_q;
				if (complete) begin
					if (len_bad) begin
						result.error_code = ERR_LENGTH;
						result.frame_last = 1'b1;
					end else begin
						result.record_length = word_new[23:0];
						if (word_new[23:0] == 24'd0) begin
							result.payload_last = 1'b1;
							result.frame_last   = last_record;
						end
					end
				end
			end
			KIND_PAYLOAD: begin
				result.title_value   = title_q;
				result.record_total  = count_q;
				result.record_index  = rec_q;
				result.record_length = len_q;
				if (rem_dec == 24'd0) begin
					result.payload_last = 1'b1;
					result.frame_last   = last_record;
				end
			end
			default: begin
				result.byte_kind = KIND_TITLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= KIND_TITLE;
			pos_q   <= 2'd0;
			title_q <= 32'd0;
			count_q <= 16'd0;
			rec_q   <= 16'd0;
			len_q   <= 24'd0;
			rem_q   <= 24'd0;
		end else if (en) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			title_q <= title_d;
			count_q <= count_d;
			rec_q   <= rec_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= word_d;
		end
	end

endmodule

### src/length_prefixed_message_deframer.sv
// Deframer for length-prefixed messages, one byte per beat.
// The slave stream (s_tvalid, s_tready, s_tdata) carries the raw message bytes:
// a 32-bit little-endian title, a 32-bit little-endian record count, then for
// each record a 32-bit little-endian length followed by that many payload bytes.
// The master stream gives one beat for every input beat, classifying the byte in
// m_tuser and reporting the header values and the current record in m_tdata;
// m_tlast marks the last byte of a message, including one cut short by an error.
// The user sets the record count and length limits through the write port
// (cfg_we, cfg_index, cfg_data) only while no bytes are in flight; not enforced.
// A beat passes through an input register and a result register before its result
// is offered on the master side. One byte is taken per cycle while the receiver
// keeps up: the state update is a single counter step and compare per byte.
// Reset returns the limits to 64 records and 65535 bytes and expects a title
// byte next. When the receiver stalls, the result is held in the result
// register and the input register still takes one byte; s_tready falls after
// that, as soon as both registers are full.
module length_prefixed_message_deframer import lpmd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // data_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// byte_value, title_value, record_total, record_index, record_length,
	// payload_last, error_code, zero fill
	output logic [OUT_DATA_W-1:0]  m_tdata,
	output logic [1:0]             m_tuser,   // byte_kind
	output logic                   m_tlast,   // frame_last
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res;
	logic        advance;
	logic [15:0] max_records_q;
	logic [23:0] max_record_length_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_records_q       <= MAX_RECORDS_RST;
			max_record_length_q <= MAX_RECORD_LENGTH_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MAX_RECORDS) begin
				max_records_q <= cfg_data[15:0];
			end else if (cfg_index == CFG_MAX_RECORD_LENGTH) begin
				max_record_length_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	lpmd_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (advance),
		.data_byte         (byte_s1),
		.max_records       (max_records_q),
		.max_record_length (max_record_length_q),
		.result            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.byte_kind;
	assign m_tlast  = res_q.frame_last;
	assign m_tdata  = {5'd0, res_q.error_code, res_q.payload_last, res_q.record_length,
		res_q.record_index, res_q.record_total, res_q.title_value, res_q.byte_value};

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with an empty result register");

	a_error_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.error_code != ERR_NONE) |-> res_q.frame_last)
		else $error("error beat without end of frame");

	a_header_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ((res_q.byte_kind == KIND_TITLE) || (res_q.byte_kind == KIND_COUNT))
		|-> (res_q.record_index == 16'd0) && (res_q.record_length == 24'd0))
		else $error("header beat carries record fields");

	a_payload_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.byte_kind == KIND_PAYLOAD) |-> (res_q.error_code == ERR_NONE))
		else $error("payload beat with an error code");

endmodule
